/* hdl/stt_pkg.sv */
// Shared types, codes and character helpers for the source text tokenizer.
// No dependencies; compiled first.
package stt_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_LCOMM, M_BCOMM, M_ID, M_INT, M_FLOAT, M_STR, M_OP, M_DONE
  } mode_t;

  localparam logic [4:0] K_EOF   = 5'd0;
  localparam logic [4:0] K_ID    = 5'd1;
  localparam logic [4:0] K_INT   = 5'd2;
  localparam logic [4:0] K_FLOAT = 5'd3;
  localparam logic [4:0] K_STR   = 5'd4;
  localparam logic [4:0] K_SEMI  = 5'd5;
  localparam logic [4:0] K_COLON = 5'd6;
  localparam logic [4:0] K_LPAR  = 5'd7;
  localparam logic [4:0] K_RPAR  = 5'd8;
  localparam logic [4:0] K_LBRK  = 5'd9;
  localparam logic [4:0] K_RBRK  = 5'd10;
  localparam logic [4:0] K_LBRC  = 5'd11;
  localparam logic [4:0] K_RBRC  = 5'd12;
  localparam logic [4:0] K_COMMA = 5'd13;
  localparam logic [4:0] K_PLUS  = 5'd14;
  localparam logic [4:0] K_MINUS = 5'd15;
  localparam logic [4:0] K_STAR  = 5'd16;
  localparam logic [4:0] K_PCT   = 5'd17;
  localparam logic [4:0] K_AND   = 5'd18;
  localparam logic [4:0] K_OR    = 5'd19;
  localparam logic [4:0] K_LT    = 5'd20;
  localparam logic [4:0] K_LE    = 5'd21;
  localparam logic [4:0] K_NE    = 5'd22;
  localparam logic [4:0] K_GT    = 5'd23;
  localparam logic [4:0] K_GE    = 5'd24;
  localparam logic [4:0] K_ASGN  = 5'd25;
  localparam logic [4:0] K_EQ    = 5'd26;
  localparam logic [4:0] K_SLASH = 5'd27;
  localparam logic [4:0] K_DSLSH = 5'd28;
  localparam logic [4:0] K_ERR   = 5'd29;

  localparam logic [2:0] E_NONE      = 3'd0;
  localparam logic [2:0] E_BAD_CHAR  = 3'd1;
  localparam logic [2:0] E_PARTIAL   = 3'd2;
  localparam logic [2:0] E_OPEN_STR  = 3'd3;
  localparam logic [2:0] E_OPEN_BCOM = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  // result entries held in the output queue
  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] tok_line;
    logic [15:0] tok_col;
    logic [15:0] tok_len;
    logic [2:0]  err_code;
    logic        last_of_run;
  } res_t;

  // up to two results per request; v1 implies v0
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic needs_partner(input logic [7:0] p);
    return p == CH_AMP || p == CH_BAR || p == CH_BANG;
  endfunction

  function automatic logic is_op_start(input logic [7:0] c);
    return c == CH_AMP || c == CH_BAR || c == CH_LT || c == CH_BANG ||
           c == CH_GT || c == CH_EQ || c == CH_SLASH;
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h3B:    k = K_SEMI;
      8'h3A:    k = K_COLON;
      8'h28:    k = K_LPAR;
      8'h29:    k = K_RPAR;
      8'h5B:    k = K_LBRK;
      8'h5D:    k = K_RBRK;
      8'h7B:    k = K_LBRC;
      8'h7D:    k = K_RBRC;
      8'h2C:    k = K_COMMA;
      8'h2B:    k = K_PLUS;
      8'h2D:    k = K_MINUS;
      8'h2A:    k = K_STAR;
      8'h25:    k = K_PCT;
      CH_LT:    k = K_LT;
      CH_GT:    k = K_GT;
      CH_EQ:    k = K_ASGN;
      CH_SLASH: k = K_SLASH;
      default:  k = K_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    logic [4:0] k;
    priority if (p == CH_AMP && c == CH_AMP)     k = K_AND;
    else if (p == CH_BAR && c == CH_BAR)         k = K_OR;
    else if (p == CH_LT && c == CH_EQ)           k = K_LE;
    else if (p == CH_BANG && c == CH_EQ)         k = K_NE;
    else if (p == CH_GT && c == CH_EQ)           k = K_GE;
    else if (p == CH_EQ && c == CH_EQ)           k = K_EQ;
    else if (p == CH_SLASH && c == CH_SLASH)     k = K_DSLSH;
    else                                         k = K_EOF;
    return k;
  endfunction

  function automatic logic [15:0] clamp16(input logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

/* hdl/stt_ifs.sv */
// Handshake interfaces for the text byte channel and the token channel.
// Depends on nothing; payload widths are fixed.
interface stt_text_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;

  modport source (output valid, op, ch, input ready);
  modport sink   (input valid, op, ch, output ready);
endinterface

interface stt_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [15:0] tok_line;
  logic [15:0] tok_col;
  logic [15:0] tok_len;
  logic [2:0]  err_code;
  logic        last_of_run;

  modport source (output valid, kind, tok_line, tok_col, tok_len, err_code, last_of_run,
                  input ready);
  modport sink   (input valid, kind, tok_line, tok_col, tok_len, err_code, last_of_run,
                  output ready);
endinterface

/* hdl/stt_lexer.sv */
// Lexer core: input register, mode/position state and per-byte result generation.
// Depends on stt_pkg and stt_text_if; feeds stt_token_fifo.
module stt_lexer #(
  parameter int LINE_BITS = 16,
  parameter int COL_BITS  = 16,
  parameter int LEN_BITS  = 16
) (
  input  logic            clk,
  input  logic            rst,
  stt_text_if.sink        text,
  input  logic            room,
  output stt_pkg::push_t  push
);
  import stt_pkg::*;

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [COL_BITS-1:0]  COL_ONE  = COL_BITS'(1);
  localparam logic [LEN_BITS-1:0]  LEN_ONE  = LEN_BITS'(1);

  typedef struct packed {
    mode_t                mode;
    logic [LINE_BITS-1:0] line_count;
    logic [COL_BITS-1:0]  col_count;
    logic [LINE_BITS-1:0] anchor_line;
    logic [COL_BITS-1:0]  anchor_col;
    logic [LEN_BITS-1:0]  run_length;
    logic [7:0]           pending_char;
    logic                 backslash_seen;
  } lex_state_t;

  typedef struct packed {
    lex_state_t s;
    logic       v;
    res_t       r;
  } idle_out_t;

  function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
    return (v != '1) ? v + LINE_ONE : v;
  endfunction

  function automatic logic [COL_BITS-1:0] col_inc(input logic [COL_BITS-1:0] v);
    return (v != '1) ? v + COL_ONE : v;
  endfunction

  function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] v);
    return (v != '1) ? v + LEN_ONE : v;
  endfunction

  function automatic res_t make_res(input logic [4:0] k, input logic [31:0] ln,
                                    input logic [31:0] col, input logic [31:0] len,
                                    input logic [2:0] err);
    res_t r;
    r.kind        = k;
    r.tok_line    = clamp16(ln);
    r.tok_col     = clamp16(col);
    r.tok_len     = clamp16(len);
    r.err_code    = err;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic lex_state_t reset_state();
    lex_state_t s;
    s.mode           = M_IDLE;
    s.line_count     = LINE_ONE;
    s.col_count      = COL_ONE;
    s.anchor_line    = '0;
    s.anchor_col     = '0;
    s.run_length     = '0;
    s.pending_char   = '0;
    s.backslash_seen = 1'b0;
    return s;
  endfunction

  // a byte seen between tokens
  function automatic idle_out_t idle_byte(input lex_state_t si, input logic [7:0] c);
    idle_out_t  o;
    logic [4:0] k;
    o.s = si;
    o.v = 1'b0;
    o.r = '0;
    k   = single_kind(c);
    priority if (c == CH_SPACE) begin
      o.s.col_count = col_inc(si.col_count);
    end else if (c == CH_LF) begin
      o.s.line_count = line_inc(si.line_count);
      o.s.col_count  = COL_ONE;
    end else if (c == CH_TILDE) begin
      o.s.anchor_line = si.line_count;
      o.s.anchor_col  = si.col_count;
      o.s.col_count   = col_inc(si.col_count);
      o.s.mode        = M_BCOMM;
    end else if (c == CH_HASH) begin
      o.s.col_count = col_inc(si.col_count);
      o.s.mode      = M_LCOMM;
    end else if (c == CH_UNDER || is_alpha(c) || is_digit(c)) begin
      o.s.anchor_col = si.col_count;
      o.s.run_length = LEN_ONE;
      o.s.col_count  = col_inc(si.col_count);
      o.s.mode       = is_digit(c) ? M_INT : M_ID;
    end else if (c == CH_QUOTE) begin
      o.s.col_count      = col_inc(si.col_count);
      o.s.anchor_col     = col_inc(si.col_count);
      o.s.run_length     = '0;
      o.s.backslash_seen = 1'b0;
      o.s.mode           = M_STR;
    end else if (is_op_start(c)) begin
      o.s.pending_char = c;
      o.s.anchor_col   = si.col_count;
      o.s.col_count    = col_inc(si.col_count);
      o.s.mode         = M_OP;
    end else if (k != K_EOF) begin
      o.v           = 1'b1;
      o.r           = make_res(k, 32'(si.line_count), 32'(si.col_count), 32'd1, E_NONE);
      o.s.col_count = col_inc(si.col_count);
    end else begin
      o.v      = 1'b1;
      o.r      = make_res(K_ERR, 32'(si.line_count), 32'(si.col_count), 32'd0, E_BAD_CHAR);
      o.s.mode = M_DONE;
    end
    return o;
  endfunction

  logic       in_valid;
  logic       op_q;
  logic [7:0] ch_q;
  logic       fire;

  lex_state_t cur;
  lex_state_t cur_next;
  lex_state_t s;
  idle_out_t  io;
  logic       a_v;
  logic       b_v;
  res_t       a_r;
  res_t       b_r;
  logic       call_idle;
  logic [4:0] pk;
  logic [4:0] run_kind;
  logic [4:0] pend_kind;
  res_t       eof_r;

  assign fire       = in_valid && room;
  assign text.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      op_q <= text.op;
      ch_q <= text.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= reset_state();
    end else if (fire) begin
      cur <= cur_next;
    end
  end

  always_comb begin
    s         = cur;
    a_v       = 1'b0;
    b_v       = 1'b0;
    a_r       = '0;
    b_r       = '0;
    call_idle = 1'b0;
    io        = '0;
    pk        = pair_kind(cur.pending_char, ch_q);
    pend_kind = single_kind(cur.pending_char);
    run_kind  = (cur.mode == M_ID) ? K_ID : ((cur.mode == M_INT) ? K_INT : K_FLOAT);
    eof_r     = make_res(K_EOF, 32'(cur.line_count), 32'(cur.col_count), 32'd0, E_NONE);

    if (op_q || (cur.mode != M_DONE && ch_q == CH_NUL)) begin
      // end of text: close any open token
      unique case (cur.mode)
        M_IDLE, M_LCOMM: begin
          a_v = 1'b1;
          a_r = eof_r;
        end
        M_ID, M_INT, M_FLOAT: begin
          a_v = 1'b1;
          a_r = make_res(run_kind, 32'(cur.line_count), 32'(cur.anchor_col),
                         32'(cur.run_length), E_NONE);
          b_v = 1'b1;
          b_r = eof_r;
        end
        M_STR: begin
          a_v = 1'b1;
          a_r = make_res(K_ERR, 32'(cur.line_count), 32'(cur.col_count), 32'd0, E_OPEN_STR);
        end
        M_BCOMM: begin
          a_v = 1'b1;
          a_r = make_res(K_ERR, 32'(cur.anchor_line), 32'(cur.anchor_col), 32'd0,
                         E_OPEN_BCOM);
        end
        M_OP: begin
          a_v = 1'b1;
          if (needs_partner(cur.pending_char)) begin
            a_r = make_res(K_ERR, 32'(cur.line_count), 32'(cur.anchor_col), 32'd0,
                           E_PARTIAL);
          end else begin
            a_r = make_res(pend_kind, 32'(cur.line_count), 32'(cur.anchor_col), 32'd1,
                           E_NONE);
            b_v = 1'b1;
            b_r = eof_r;
          end
        end
        default: begin
        end
      endcase
      s.mode = M_DONE;
      if (op_q) begin
        s = reset_state();
      end
    end else if (cur.mode != M_DONE) begin
      unique case (cur.mode)
        M_IDLE: call_idle = 1'b1;
        M_LCOMM: begin
          if (ch_q == CH_LF) begin
            s.mode    = M_IDLE;
            call_idle = 1'b1;
          end else begin
            s.col_count = col_inc(cur.col_count);
          end
        end
        M_BCOMM: begin
          s.col_count = col_inc(cur.col_count);
          if (ch_q == CH_TILDE) begin
            s.mode = M_IDLE;
          end
        end
        M_ID: begin
          if (ch_q == CH_UNDER || is_alpha(ch_q) || is_digit(ch_q)) begin
            s.run_length = len_inc(cur.run_length);
            s.col_count  = col_inc(cur.col_count);
          end else begin
            a_v       = 1'b1;
            a_r       = make_res(K_ID, 32'(cur.line_count), 32'(cur.anchor_col),
                                 32'(cur.run_length), E_NONE);
            s.mode    = M_IDLE;
            call_idle = 1'b1;
          end
        end
        M_INT, M_FLOAT: begin
          if (is_digit(ch_q) || (cur.mode == M_INT && ch_q == CH_DOT)) begin
            if (ch_q == CH_DOT) begin
              s.mode = M_FLOAT;
            end
            s.run_length = len_inc(cur.run_length);
            s.col_count  = col_inc(cur.col_count);
          end else begin
            a_v       = 1'b1;
            a_r       = make_res(run_kind, 32'(cur.line_count), 32'(cur.anchor_col),
                                 32'(cur.run_length), E_NONE);
            s.mode    = M_IDLE;
            call_idle = 1'b1;
          end
        end
        M_STR: begin
          if (ch_q == CH_QUOTE && !cur.backslash_seen) begin
            a_v         = 1'b1;
            a_r         = make_res(K_STR, 32'(cur.line_count), 32'(cur.anchor_col),
                                   32'(cur.run_length), E_NONE);
            s.col_count = col_inc(cur.col_count);
            s.mode      = M_IDLE;
          end else begin
            s.run_length     = len_inc(cur.run_length);
            s.backslash_seen = (ch_q == CH_BSLASH);
            s.col_count      = col_inc(cur.col_count);
          end
        end
        M_OP: begin
          a_v = 1'b1;
          if (pk != K_EOF) begin
            a_r         = make_res(pk, 32'(cur.line_count), 32'(cur.col_count), 32'd2,
                                   E_NONE);
            s.col_count = col_inc(cur.col_count);
            s.mode      = M_IDLE;
          end else if (needs_partner(cur.pending_char)) begin
            a_r    = make_res(K_ERR, 32'(cur.line_count), 32'(cur.anchor_col), 32'd0,
                              E_PARTIAL);
            s.mode = M_DONE;
          end else begin
            a_r       = make_res(pend_kind, 32'(cur.line_count), 32'(cur.anchor_col), 32'd1,
                                 E_NONE);
            s.mode    = M_IDLE;
            call_idle = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (call_idle) begin
        io  = idle_byte(s, ch_q);
        s   = io.s;
        b_v = io.v;
        b_r = io.r;
      end
    end
    cur_next = s;

    // pack the results so that a single one always sits in the first slot
    push.v0             = fire && (a_v || b_v);
    push.v1             = fire && a_v && b_v;
    push.r0             = a_v ? a_r : b_r;
    push.r0.last_of_run = !(a_v && b_v);
    push.r1             = b_r;
    push.r1.last_of_run = 1'b1;
  end

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    fire && op_q |=> cur.mode == M_IDLE && cur.line_count == LINE_ONE &&
                     cur.col_count == COL_ONE)
    else $error("state not back to reset after end request");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    fire && !op_q && cur.mode == M_DONE |-> !push.v0)
    else $error("result produced after an error or end byte");

  a_nul_done: assert property (@(posedge clk) disable iff (rst)
    fire && !op_q && ch_q == CH_NUL |=> cur.mode == M_DONE)
    else $error("zero byte did not close the text");

endmodule

/* hdl/stt_token_fifo.sv */
// Small result queue between the lexer and the token channel; takes up to two
// results a cycle and hands out one. Depends on stt_pkg and stt_token_if.
module stt_token_fifo (
  input  logic            clk,
  input  logic            rst,
  input  stt_pkg::push_t  push,
  output logic            room,
  stt_token_if.source     tokens
);
  import stt_pkg::*;

  // depth must be a power of two so that pointers wrap by themselves
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr;
  logic [PTR_W-1:0] rd;
  logic [PTR_W-1:0] wr_p1;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pop;
  res_t             head;

  assign wr_p1      = wr + PTR_W'(1);
  assign pop        = tokens.valid && tokens.ready;
  assign room       = count <= CNT_W'(FIFO_DEPTH - 2);
  assign count_next = count + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + PTR_W'(push.v0) + PTR_W'(push.v1);
      rd    <= rd + PTR_W'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_p1] <= push.r1;
    end
  end

  assign head               = mem[rd];
  assign tokens.valid       = count != '0;
  assign tokens.kind        = head.kind;
  assign tokens.tok_line    = head.tok_line;
  assign tokens.tok_col     = head.tok_col;
  assign tokens.tok_len     = head.tok_len;
  assign tokens.err_code    = head.err_code;
  assign tokens.last_of_run = head.last_of_run;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.v0 |-> count <= CNT_W'(FIFO_DEPTH - 2))
    else $error("results pushed without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

/* hdl/source_text_tokenizer_core.sv */
// Source text tokenizer, top level: lexer core followed by the result queue.
// Depends on stt_pkg, stt_ifs, stt_lexer and stt_token_fifo.
//
// Use: source text enters on the text channel, one byte per request with
// op = 0, and each text is closed by a request with op = 1. Token descriptors
// leave on the tokens channel, one per request; last_of_run marks the final
// descriptor caused by one text request (a request causes zero, one or two).
// A byte taken on the text channel is held in the input register, then lexed
// and written into the queue once it has room; the queue then offers its tokens.
// Throughput: one text request per cycle, set by the combinational mode and
// position update. The four-entry result queue takes two results per cycle;
// while it holds more than two, the lexer stalls and text.ready falls, so a
// run of two-result bytes against a slow receiver slows to its pace.
// Reset (rst, synchronous) returns the lexer to line 1, column 1 between
// tokens and empties the queue. A stalled receiver simply leaves results in
// the queue; nothing is dropped. After an error or a zero byte, bytes are
// ignored until the end request, which then restores the reset state.
module source_text_tokenizer_core #(
  parameter int LINE_BITS = 16,
  parameter int COL_BITS  = 16,
  parameter int LEN_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  stt_text_if.sink     text,
  stt_token_if.source  tokens
);
  import stt_pkg::*;

  push_t push;
  logic  room;

  stt_lexer #(
    .LINE_BITS (LINE_BITS),
    .COL_BITS  (COL_BITS),
    .LEN_BITS  (LEN_BITS)
  ) u_lexer (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .room (room),
    .push (push)
  );

  stt_token_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .tokens (tokens)
  );

endmodule
